FILE: rtl/rtmpd_pkg.sv
// ----------------------------------------------------------------------------
// rtmpd_pkg
// Shared types, constants and helpers of the RTMP chunk stream deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package rtmpd_pkg;

  localparam int NUM_CHUNK_STREAMS_DEF   = 64;
  localparam int HANDSHAKE_SIG_BYTES_DEF = 1536;

  localparam logic [23:0] MAX_CHUNK_RESET = 24'd128;
  localparam logic [23:0] EXT_MARK        = 24'hFFFFFF;

  typedef enum logic [1:0] {
    KIND_C0C1    = 2'd0,
    KIND_C2      = 2'd1,
    KIND_PAYLOAD = 2'd2,
    KIND_EMPTY   = 2'd3
  } kind_t;

  localparam logic [1:0] FMT_FULL  = 2'd0;
  localparam logic [1:0] FMT_DELTA = 2'd1;
  localparam logic [1:0] FMT_TS    = 2'd2;
  localparam logic [1:0] FMT_CONT  = 2'd3;

  // per chunk stream record
  typedef struct packed {
    logic [1:0]  fmt;
    logic [31:0] prev_epoch;
    logic [31:0] prev_ts;
    logic [31:0] prev_sid;
    logic [31:0] prev_tl;
    logic [31:0] msg_epoch;
    logic [31:0] msg_ts;
    logic [31:0] msg_sid;
    logic [31:0] msg_tl;
    logic        active;
    logic [23:0] rd;
  } rec_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic [5:0]  csid;
    logic [7:0]  mtype;
    logic [31:0] sid;
    logic [31:0] epoch;
    logic [31:0] ts;
    logic [23:0] len;
    logic        last;
  } res_t;

  function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
    logic [3:0] n;
    case (fmt)
      FMT_FULL:  n = 4'd11;
      FMT_DELTA: n = 4'd7;
      default:   n = 4'd3;
    endcase
    return n;
  endfunction

  function automatic rec_t complete_msg(input rec_t r);
    rec_t o;
    o = r;
    o.prev_epoch = r.msg_epoch;
    o.prev_ts    = r.msg_ts;
    o.prev_sid   = r.msg_sid;
    o.prev_tl    = r.msg_tl;
    o.active     = 1'b0;
    o.rd         = '0;
    return o;
  endfunction

  function automatic rec_t set_epoch(input rec_t r, input logic [31:0] ts);
    rec_t o;
    o = r;
    o.msg_ts = ts;
    if (r.fmt == FMT_FULL) begin
      o.msg_epoch = ts;
    end else begin
      o.msg_epoch = r.prev_epoch + ts;
    end
    return o;
  endfunction

  function automatic res_t mk_res(input kind_t k, input logic [7:0] d, input logic [5:0] csid,
                                  input rec_t r, input logic last);
    res_t o;
    o.kind  = k;
    o.data  = d;
    o.csid  = csid;
    o.mtype = r.msg_tl[31:24];
    o.sid   = r.msg_sid;
    o.epoch = r.msg_epoch;
    o.ts    = r.msg_ts;
    o.len   = r.msg_tl[23:0];
    o.last  = last;
    return o;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/rtmpd_stream_mem.sv
// ----------------------------------------------------------------------------
// rtmpd_stream_mem
// Per chunk stream record store: one write and one registered read port.
// Entries never written read as zero through flop valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmpd_stream_mem #(
  parameter int DEPTH = rtmpd_pkg::NUM_CHUNK_STREAMS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire rtmpd_pkg::rec_t  wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output rtmpd_pkg::rec_t       rd_data
);

  rtmpd_pkg::rec_t mem [DEPTH];
  rtmpd_pkg::rec_t rd_q;
  logic [DEPTH-1:0] vld;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

`default_nettype wire

FILE: rtl/rtmp_chunk_stream_deframer.sv
// ----------------------------------------------------------------------------
// rtmp_chunk_stream_deframer
// Passes the C0C1 and C2 handshake, then parses chunk headers and emits
// payload bytes with message metadata, one byte per request.
// ----------------------------------------------------------------------------
// channel  signals                          dir  role
// in       in_valid in_ready data_byte      in   received byte stream
// out      out_valid out_ready kind ...     out  one result per request or none
// cfg      cfg_valid cfg_ready chunk_size_in in  chunk size register write
//
// One byte per cycle outside PH_LOAD while the output is not stalled; a basic
// header byte leads to PH_LOAD, which takes its record from the table memory.
// The current stream's record lives in a working register and is written
// back when the next basic header arrives. A same-stream read is forwarded.
// Reset clears the table valid bits at once; no clearing pass.
// Past the load cycle, the input stalls only while the output register is
// full and not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmp_chunk_stream_deframer #(
  parameter int NUM_CHUNK_STREAMS   = rtmpd_pkg::NUM_CHUNK_STREAMS_DEF,
  parameter int HANDSHAKE_SIG_BYTES = rtmpd_pkg::HANDSHAKE_SIG_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [23:0] chunk_size_in,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       kind,
  output logic [7:0]       out_byte,
  output logic [5:0]       chunk_stream_id,
  output logic [7:0]       message_type,
  output logic [31:0]      message_stream_id,
  output logic [31:0]      epoch_time,
  output logic [31:0]      header_timestamp,
  output logic [23:0]      message_length,
  output logic             last_of_message
);

  localparam int SLOT_W  = $clog2(NUM_CHUNK_STREAMS);
  localparam int CNT_RAW = $clog2(HANDSHAKE_SIG_BYTES + 2);
  localparam int CNT_W   = (CNT_RAW > 4) ? CNT_RAW : 4;

  typedef enum logic [6:0] {
    PH_C0C1   = 7'b0000001,
    PH_C2     = 7'b0000010,
    PH_BASIC  = 7'b0000100,
    PH_LOAD   = 7'b0001000,
    PH_HEADER = 7'b0010000,
    PH_EXT    = 7'b0100000,
    PH_CHUNK  = 7'b1000000
  } phase_t;

  function automatic logic [SLOT_W-1:0] slot_of(input logic [5:0] cid);
    int r;
    r = int'(cid);
    for (int k = 5; k >= 0; k--) begin
      if (r >= (NUM_CHUNK_STREAMS << k)) begin
        r = r - (NUM_CHUNK_STREAMS << k);
      end
    end
    return SLOT_W'(r);
  endfunction

  phase_t            phase, phase_next;
  logic [CNT_W-1:0]  cnt, cnt_next, cnt_inc;
  logic [63:0]       shift, shift_next, sh;
  logic [23:0]       crem, crem_next;
  logic [23:0]       max_chunk;
  logic [5:0]        cur_stream;
  logic [SLOT_W-1:0] cur_slot, new_slot;
  logic [1:0]        pend_fmt;
  logic              fwd;
  rtmpd_pkg::rec_t   w, w_next, mem_rdata;
  rtmpd_pkg::res_t   res, out_q;
  logic              res_v;
  logic              in_fire, basic_fire;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (!out_valid || out_ready) && (phase != PH_LOAD);
  assign in_fire    = in_valid && in_ready;
  assign basic_fire = in_fire && (phase == PH_BASIC);
  assign new_slot   = slot_of(data_byte[5:0]);

  rtmpd_stream_mem #(
    .DEPTH (NUM_CHUNK_STREAMS),
    .AW    (SLOT_W)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (basic_fire),
    .wr_addr (cur_slot),
    .wr_data (w),
    .rd_en   (basic_fire),
    .rd_addr (new_slot),
    .rd_data (mem_rdata)
  );

  always_comb begin
    rtmpd_pkg::rec_t r, bc_rec;
    logic            bc, last;
    logic [23:0]     ts24, len, diff, rem, crem_d;
    phase_next = phase;
    cnt_next   = cnt;
    shift_next = shift;
    crem_next  = crem;
    w_next     = w;
    res        = '0;
    res_v      = 1'b0;
    bc         = 1'b0;
    bc_rec     = w;
    r          = w;
    last       = 1'b0;
    ts24       = crem;
    len        = '0;
    diff       = '0;
    rem        = '0;
    crem_d     = '0;
    sh         = {shift[55:0], data_byte};
    cnt_inc    = cnt + CNT_W'(1);
    unique case (phase)
      PH_C0C1: begin
        if (in_fire) begin
          res_v = 1'b1;
          if (cnt_inc >= CNT_W'(HANDSHAKE_SIG_BYTES + 1)) begin
            res        = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_C0C1, data_byte, '0, '0, 1'b1);
            cnt_next   = '0;
            phase_next = PH_C2;
          end else begin
            res      = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_C0C1, data_byte, '0, '0, 1'b0);
            cnt_next = cnt_inc;
          end
        end
      end
      PH_C2: begin
        if (in_fire) begin
          res_v = 1'b1;
          if (cnt_inc >= CNT_W'(HANDSHAKE_SIG_BYTES)) begin
            res        = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_C2, data_byte, '0, '0, 1'b1);
            cnt_next   = '0;
            phase_next = PH_BASIC;
          end else begin
            res      = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_C2, data_byte, '0, '0, 1'b0);
            cnt_next = cnt_inc;
          end
        end
      end
      PH_BASIC: begin
        if (in_fire) begin
          phase_next = PH_LOAD;
        end
      end
      PH_LOAD: begin
        r     = fwd ? w : mem_rdata;
        r.fmt = pend_fmt;
        if (pend_fmt != rtmpd_pkg::FMT_CONT) begin
          cnt_next   = '0;
          shift_next = '0;
          crem_next  = '0;
          phase_next = PH_HEADER;
          w_next     = r;
        end else begin
          if (!r.active) begin
            r.msg_tl    = r.prev_tl;
            r.msg_ts    = r.prev_ts;
            r.msg_epoch = r.prev_epoch + r.prev_ts;
            r.msg_sid   = r.prev_sid;
            r.active    = 1'b1;
            r.rd        = '0;
          end
          bc     = 1'b1;
          bc_rec = r;
        end
      end
      PH_HEADER: begin
        if (in_fire) begin
          cnt_next = cnt_inc;
          if (cnt_inc == CNT_W'(3)) begin
            crem_next  = sh[23:0];
            shift_next = '0;
            ts24       = sh[23:0];
          end else begin
            shift_next = sh;
          end
          if (cnt_inc >= CNT_W'(rtmpd_pkg::hdr_len(w.fmt))) begin
            r = w;
            if (w.fmt == rtmpd_pkg::FMT_FULL) begin
              r.msg_tl  = {sh[39:32], sh[63:40]};
              r.msg_sid = {sh[7:0], sh[15:8], sh[23:16], sh[31:24]};
            end else if (w.fmt == rtmpd_pkg::FMT_DELTA) begin
              r.msg_tl  = {sh[7:0], sh[31:8]};
              r.msg_sid = w.prev_sid;
            end else begin
              r.msg_tl  = w.prev_tl;
              r.msg_sid = w.prev_sid;
            end
            r.active  = 1'b1;
            r.rd      = '0;
            crem_next = '0;
            if (ts24 != rtmpd_pkg::EXT_MARK) begin
              bc     = 1'b1;
              bc_rec = rtmpd_pkg::set_epoch(r, {8'h00, ts24});
            end else begin
              r.msg_ts   = {8'h00, ts24};
              w_next     = r;
              cnt_next   = '0;
              shift_next = '0;
              phase_next = PH_EXT;
            end
          end
        end
      end
      PH_EXT: begin
        if (in_fire) begin
          cnt_next   = cnt_inc;
          shift_next = sh;
          if (cnt_inc >= CNT_W'(4)) begin
            bc     = 1'b1;
            bc_rec = rtmpd_pkg::set_epoch(w, sh[31:0]);
          end
        end
      end
      PH_CHUNK: begin
        if (in_fire) begin
          r.rd      = w.rd + 24'd1;
          r.active  = 1'b1;
          crem_d    = (crem != '0) ? crem - 24'd1 : '0;
          crem_next = crem_d;
          if (crem_d == '0) begin
            phase_next = PH_BASIC;
            last       = (r.rd == w.msg_tl[23:0]);
          end
          res_v  = 1'b1;
          res    = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_PAYLOAD, data_byte, cur_stream, w, last);
          w_next = last ? rtmpd_pkg::complete_msg(r) : r;
        end
      end
      default: begin
        phase_next = PH_BASIC;
      end
    endcase

    // start of a chunk: payload window or empty message
    if (bc) begin
      len = bc_rec.msg_tl[23:0];
      if (bc_rec.rd < len) begin
        diff       = len - bc_rec.rd;
        rem        = (diff > max_chunk) ? max_chunk : diff;
        crem_next  = rem;
        phase_next = (rem != '0) ? PH_CHUNK : PH_BASIC;
        w_next     = bc_rec;
      end else begin
        res_v      = 1'b1;
        res        = rtmpd_pkg::mk_res(rtmpd_pkg::KIND_EMPTY, 8'h00, cur_stream, bc_rec, 1'b1);
        w_next     = rtmpd_pkg::complete_msg(bc_rec);
        phase_next = PH_BASIC;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_C0C1;
      cnt        <= '0;
      shift      <= '0;
      crem       <= '0;
      max_chunk  <= rtmpd_pkg::MAX_CHUNK_RESET;
      cur_stream <= '0;
      cur_slot   <= '0;
      pend_fmt   <= '0;
      fwd        <= 1'b0;
      w          <= '0;
      out_valid  <= 1'b0;
    end else begin
      phase <= phase_next;
      cnt   <= cnt_next;
      shift <= shift_next;
      crem  <= crem_next;
      w     <= w_next;
      if (cfg_valid && cfg_ready) begin
        max_chunk <= chunk_size_in;
      end
      if (basic_fire) begin
        cur_stream <= data_byte[5:0];
        cur_slot   <= new_slot;
        pend_fmt   <= data_byte[7:6];
        fwd        <= (new_slot == cur_slot);
      end
      if (res_v) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_v) begin
      out_q <= res;
    end
  end

  assign kind              = out_q.kind;
  assign out_byte          = out_q.data;
  assign chunk_stream_id   = out_q.csid;
  assign message_type      = out_q.mtype;
  assign message_stream_id = out_q.sid;
  assign epoch_time        = out_q.epoch;
  assign header_timestamp  = out_q.ts;
  assign message_length    = out_q.len;
  assign last_of_message   = out_q.last;

endmodule

`default_nettype wire

FILE: rtl/rtmpd_checker.sv
// ----------------------------------------------------------------------------
// rtmpd_checker
// Port level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rtmpd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  out_byte,
  input wire logic [5:0]  chunk_stream_id,
  input wire logic [31:0] epoch_time,
  input wire logic [23:0] message_length,
  input wire logic        last_of_message
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
      && $stable(last_of_message))
    else $error("stalled result changed");

  // a full, untaken output register blocks input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

  a_empty_msg: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == rtmpd_pkg::KIND_EMPTY |-> last_of_message && out_byte == 8'h00)
    else $error("empty message not flagged last");

  a_hs_meta: assert property (@(posedge clk) disable iff (rst)
    out_valid && (kind == rtmpd_pkg::KIND_C0C1 || kind == rtmpd_pkg::KIND_C2)
      |-> chunk_stream_id == 6'd0 && message_length == 24'd0 && epoch_time == 32'd0)
    else $error("handshake byte carries metadata");

endmodule

bind rtmp_chunk_stream_deframer rtmpd_checker u_rtmpd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .kind            (kind),
  .out_byte        (out_byte),
  .chunk_stream_id (chunk_stream_id),
  .epoch_time      (epoch_time),
  .message_length  (message_length),
  .last_of_message (last_of_message)
);

`default_nettype wire
